[sv/sda_pkg.sv]
package sda_pkg;

  localparam int NUM_DOMAINS = 4;
  localparam int DOM_W       = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
  localparam int CNT_W       = $clog2(NUM_DOMAINS + 1);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [31:0] DECAY_RESET    = 32'd60;
  localparam logic [1:0]  CORR_SEV_RESET = 2'd2;
  localparam logic [3:0]  CORR_CNT_RESET = 4'd2;

  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_DECAY_PERIOD = 2'd0,
    CFG_CORR_SEV     = 2'd1,
    CFG_CORR_CNT     = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_REPORT = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Classified request handed from the front end to the executor.
  typedef struct packed {
    op_t         op;
    logic        dom_ok;
    logic [2:0]  domain;
    logic [1:0]  severity;
    logic [31:0] time_sec;
  } cmd_t;

endpackage

[sv/sda_front.sv]
module sda_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [2:0]        in_domain,
  input  logic [1:0]        in_severity,
  input  logic [31:0]       in_time_sec,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output sda_pkg::cmd_t     cmd
);

  sda_pkg::cmd_t                 q_r [sda_pkg::QDEPTH];
  logic [sda_pkg::QPTR_W-1:0]    wptr_r, wptr_nxt;
  logic [sda_pkg::QPTR_W-1:0]    rptr_r, rptr_nxt;
  logic [sda_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  sda_pkg::cmd_t                 cls;
  logic                          push, pop;

  always_comb begin
    cls.dom_ok   = ({1'b0, in_domain} < 4'(sda_pkg::NUM_DOMAINS));
    cls.domain   = in_domain;
    cls.severity = in_severity;
    cls.time_sec = in_time_sec;
    case (sda_pkg::kind_t'(in_kind))
      sda_pkg::KIND_REPORT: cls.op = cls.dom_ok ? sda_pkg::OP_REPORT : sda_pkg::OP_NOP;
      sda_pkg::KIND_TICK:   cls.op = sda_pkg::OP_TICK;
      sda_pkg::KIND_CLEAR:  cls.op = sda_pkg::OP_CLEAR;
      default:              cls.op = sda_pkg::OP_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != sda_pkg::QCNT_W'(sda_pkg::QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == sda_pkg::QPTR_W'(sda_pkg::QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == sda_pkg::QPTR_W'(sda_pkg::QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cls;
    end
  end

endmodule

[sv/sda_back.sv]
module sda_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  sda_pkg::cmd_t     cmd,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_threat_level,
  output logic [2:0]        out_dominant_domain,
  output logic [7:0]        out_active_mask,
  output logic [1:0]        out_domain_level
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ELAP = 5'b00010,
    S_CMP  = 5'b00100,
    S_UPD  = 5'b01000,
    S_SUM  = 5'b10000
  } state_t;

  localparam int N = sda_pkg::NUM_DOMAINS;

  state_t                      state_r, state_nxt;
  logic [1:0]                  sev_r  [N];
  logic [31:0]                 time_r [N];
  logic [sda_pkg::DOM_W-1:0]   idx_r;
  logic [sda_pkg::DOM_W-1:0]   rd_idx_r;
  logic                        rd_ok_r;
  logic [31:0]                 now_r;
  logic [31:0]                 elapsed_r;
  logic                        act_r;
  logic [1:0]                  step_r;
  logic [31:0]                 adv_r;

  logic [31:0]                 period_r;
  logic [32:0]                 period2_r;
  logic [33:0]                 period3_r;
  logic [1:0]                  corr_sev_r;
  logic [3:0]                  corr_cnt_r;

  logic                        out_valid_r;
  logic [1:0]                  lvl_r;
  logic [2:0]                  best_r;
  logic [7:0]                  mask_r;
  logic [1:0]                  dlev_r;

  logic                        ge1, ge2, ge3;
  logic [1:0]                  step_nxt;
  logic                        out_load;
  logic [1:0]                  max_sev;
  logic [sda_pkg::DOM_W-1:0]   best;
  logic [sda_pkg::CNT_W-1:0]   corr;
  logic [7:0]                  mask;
  logic [1:0]                  lvl;
  logic                        last_dom;

  assign cmd_ready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_SUM) && (!out_valid_r || out_ready);
  assign last_dom  = (idx_r == sda_pkg::DOM_W'(N - 1));

  // Configuration; twice and three times the period are kept for the decay compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= sda_pkg::DECAY_RESET;
      period2_r  <= {sda_pkg::DECAY_RESET, 1'b0};
      period3_r  <= {2'b00, sda_pkg::DECAY_RESET} + {1'b0, sda_pkg::DECAY_RESET, 1'b0};
      corr_sev_r <= sda_pkg::CORR_SEV_RESET;
      corr_cnt_r <= sda_pkg::CORR_CNT_RESET;
    end else if (cfg_we) begin
      case (sda_pkg::cfg_idx_t'(cfg_index))
        sda_pkg::CFG_DECAY_PERIOD: begin
          period_r  <= cfg_wdata;
          period2_r <= {cfg_wdata, 1'b0};
          period3_r <= {2'b00, cfg_wdata} + {1'b0, cfg_wdata, 1'b0};
        end
        sda_pkg::CFG_CORR_SEV: corr_sev_r <= cfg_wdata[1:0];
        sda_pkg::CFG_CORR_CNT: corr_cnt_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.op == sda_pkg::OP_TICK) ? S_ELAP : S_SUM;
        end
      end
      S_ELAP:  state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = last_dom ? S_SUM : S_ELAP;
      S_SUM:   state_nxt = out_load ? S_IDLE : S_SUM;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Whole decay periods elapsed, saturated at three since severity never exceeds it.
  always_comb begin
    ge1 = (elapsed_r >= period_r);
    ge2 = ({1'b0, elapsed_r} >= period2_r);
    ge3 = ({2'b00, elapsed_r} >= period3_r);
    if (ge3) begin
      step_nxt = 2'd3;
    end else if (ge2) begin
      step_nxt = 2'd2;
    end else if (ge1) begin
      step_nxt = 2'd1;
    end else begin
      step_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < N; i++) begin
        sev_r[i]  <= '0;
        time_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && cmd_valid) begin
        if (cmd.op == sda_pkg::OP_REPORT) begin
          sev_r[cmd.domain[sda_pkg::DOM_W-1:0]]  <= cmd.severity;
          time_r[cmd.domain[sda_pkg::DOM_W-1:0]] <= cmd.time_sec;
        end else if (cmd.op == sda_pkg::OP_CLEAR) begin
          for (int i = 0; i < N; i++) begin
            sev_r[i]  <= '0;
            time_r[i] <= '0;
          end
        end
      end
      if (state_r == S_UPD && act_r && step_r != 2'd0) begin
        // Once a domain reaches zero its stored time is never read again.
        sev_r[idx_r]  <= (step_r >= sev_r[idx_r]) ? 2'd0 : sev_r[idx_r] - step_r;
        time_r[idx_r] <= time_r[idx_r] + adv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        idx_r    <= '0;
        now_r    <= cmd.time_sec;
        rd_ok_r  <= cmd.dom_ok;
        rd_idx_r <= cmd.domain[sda_pkg::DOM_W-1:0];
      end
      S_ELAP: begin
        elapsed_r <= now_r - time_r[idx_r];
        act_r     <= (sev_r[idx_r] != 2'd0) && (now_r > time_r[idx_r]) && (period_r != '0);
      end
      S_CMP: begin
        step_r <= step_nxt;
        adv_r  <= ge2 ? period2_r[31:0] : period_r;
      end
      S_UPD: begin
        idx_r <= idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    max_sev = '0;
    best    = '0;
    corr    = '0;
    mask    = '0;
    for (int i = 0; i < N; i++) begin
      if (sev_r[i] > max_sev) begin
        max_sev = sev_r[i];
        best    = sda_pkg::DOM_W'(i);
      end
      if (sev_r[i] >= corr_sev_r) begin
        corr = corr + 1'b1;
      end
      mask[i] = (sev_r[i] != 2'd0);
    end
    lvl = max_sev;
    if (4'(corr) >= corr_cnt_r && max_sev != 2'd3) begin
      lvl = max_sev + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      lvl_r  <= lvl;
      best_r <= 3'(best);
      mask_r <= mask;
      dlev_r <= rd_ok_r ? sev_r[rd_idx_r] : 2'd0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_threat_level    = lvl_r;
  assign out_dominant_domain = best_r;
  assign out_active_mask     = mask_r;
  assign out_domain_level    = dlev_r;

endmodule

[sv/severity_decay_aggregator_top.sv]
// Severity decay aggregator: tracks a 0..3 severity and a report time per domain.
// Input channel (in_valid/in_ready) carries requests: kind 0 reports a severity
// for one domain, kind 1 is a time tick that decays aged domains, kind 2 clears
// all domains. Every request yields exactly one result on the out_valid/out_ready
// channel: overall threat level, dominant domain, active mask and the addressed
// domain's level. The cfg_we/cfg_index/cfg_wdata port writes decay period,
// correlation severity and correlation count; write only while the block is idle.
// A two-entry queue decouples request intake from the executor.
// Report, clear and unused kinds pass straight to the result register; a tick
// first visits each domain in turn through a subtract, compare and update
// sequence. The executor takes the next request only once it has loaded the
// result of the last one.
// Reset (rst_n low, synchronous) zeroes all domains, empties the queue and loads
// the default configuration. If the receiver holds out_ready low, the result
// stays registered, the executor waits, and in_ready drops once the queue fills.
module severity_decay_aggregator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_domain,
  input  logic [1:0]  in_severity,
  input  logic [31:0] in_time_sec,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_threat_level,
  output logic [2:0]  out_dominant_domain,
  output logic [7:0]  out_active_mask,
  output logic [1:0]  out_domain_level,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic          cmd_valid;
  logic          cmd_ready;
  sda_pkg::cmd_t cmd;

  sda_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_domain   (in_domain),
    .in_severity (in_severity),
    .in_time_sec (in_time_sec),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  sda_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (cmd_valid),
    .cmd_ready           (cmd_ready),
    .cmd                 (cmd),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_threat_level    (out_threat_level),
    .out_dominant_domain (out_dominant_domain),
    .out_active_mask     (out_active_mask),
    .out_domain_level    (out_domain_level)
  );

endmodule
